// ===== sv/hla_pkg.sv =====
// Package for the hole list allocator: item types, policy codes, header size.
// Used by every module of the allocator.
`timescale 1ns / 1ps
package hla_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned SPACE_W = 20;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 1;

  localparam logic [IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [IDX_W-1:0] REG_INITIAL_END = 1'd1;

  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;
  // spare code, keeps arrival order like first fit
  localparam logic [1:0] POL_UNUSED = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [9:0]        payload_len;
    logic [SIZE_W-1:0] free_size;
    logic [OFF_W-1:0]  free_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]   grant_offset;
    logic               from_end;
    logic               status;
    logic [CNT_W-1:0]   hole_count;
    logic [SPACE_W-1:0] hole_space;
  } out_item_t;

endpackage

// ===== sv/hole_list_allocator.sv =====
// Top level of the hole list allocator: sequencer, hole memory, result register.
// Depends on hla_pkg.
`timescale 1ns / 1ps
// An item takes several passes over the hole memory, which has one write
// port and one read port with a registered read. An allocate scans the held
// holes for the first fit, removes the hit by shifting later entries down
// and, if a residual remains, inserts it. An insert appends (first fit or the
// spare code) or walks from the tail shifting entries ranked after the new
// hole up one slot. A free is an insert alone. The first insert after a
// policy write under best or worst fit also re-sorts the whole list by
// insertion sort. Ready is low while an item is in work; the result waits in
// an output register and the next item is taken while it waits. No clearing
// pass after reset: the list starts empty.
module hole_list_allocator #(
  parameter int unsigned HOLE_SLOTS = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [hla_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [hla_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  hla_pkg::in_item_t       in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output hla_pkg::out_item_t      out_item_o
);
  import hla_pkg::*;

  localparam int unsigned AW = $clog2(HOLE_SLOTS);
  localparam int unsigned HW = $clog2(HOLE_SLOTS + 1);
  localparam int unsigned TW = SIZE_W + HW;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SCAN   = 12'b000000000010,
    S_SCHK   = 12'b000000000100,
    S_SHDN   = 12'b000000001000,
    S_INS    = 12'b000000010000,
    S_IRD    = 12'b000000100000,
    S_ICHK   = 12'b000001000000,
    S_DONE   = 12'b000010000000,
    S_APP    = 12'b000100000000,
    S_SHDW   = 12'b001000000000,
    S_SRD    = 12'b010000000000,
    S_SLD    = 12'b100000000000
  } state_e;

  state_e state_q;
  logic [1:0]        pol_q;
  logic [OFF_W-1:0]  end_q;
  logic [HW-1:0]     held_q;
  logic [TW-1:0]     total_q;
  logic [HW-1:0]     idx_q, k_q;
  logic [SIZE_W-1:0] need_q, ins_size_q;
  logic [OFF_W-1:0]  ins_off_q, grant_q;
  logic              from_end_q, status_q;
  logic              ord_q, sort_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // hole memory: one write port and one read port, registered read
  logic [SIZE_W+OFF_W-1:0] mem [HOLE_SLOTS];
  logic [SIZE_W+OFF_W-1:0] rd_q, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [SIZE_W-1:0] rd_size;
  logic [OFF_W-1:0]  rd_off;
  assign rd_size = rd_q[SIZE_W+OFF_W-1:OFF_W];
  assign rd_off  = rd_q[OFF_W-1:0];

  // new hole ranks ahead of the entry read
  logic ahead;
  always_comb begin
    if (pol_q == POL_BEST)
      ahead = (ins_size_q != rd_size) ? (ins_size_q < rd_size) : (ins_off_q < rd_off);
    else
      ahead = (ins_size_q != rd_size) ? (ins_size_q > rd_size) : (ins_off_q < rd_off);
  end

  logic sorted;
  assign sorted = (pol_q == POL_BEST) || (pol_q == POL_WORST);

  logic [SIZE_W-1:0] need_c;
  assign need_c = SIZE_W'(in_item_i.payload_len) + SIZE_W'(HEADER_BYTES);

  logic [HW-1:0] idx_m1, idx_p1;
  assign idx_m1 = idx_q - HW'(1);
  assign idx_p1 = idx_q + HW'(1);

  // move the entry below up one slot instead of placing the new hole
  logic shift_up;
  assign shift_up = (idx_q != '0) && sorted && ahead;

  always_comb begin
    raddr = idx_q[AW-1:0];
    waddr = idx_q[AW-1:0];
    wdata = {ins_size_q, ins_off_q};
    we = 1'b0;
    case (state_q)
      S_IDLE: ;
      S_SCAN: ;   // read issued at idx_q
      S_SCHK: ;
      S_SHDN: raddr = idx_p1[AW-1:0];
      S_SHDW: begin
        we = 1'b1;
        wdata = rd_q;
      end
      S_INS: ;
      S_APP: we = 1'b1;
      S_SRD: raddr = k_q[AW-1:0];
      S_SLD: ;
      S_IRD: raddr = idx_m1[AW-1:0];
      S_ICHK: begin
        we = 1'b1;
        wdata = shift_up ? rd_q : {ins_size_q, ins_off_q};
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pol_q       <= POL_FIRST;
      end_q       <= '0;
      held_q      <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      need_q      <= '0;
      ins_size_q  <= '0;
      ins_off_q   <= '0;
      grant_q     <= '0;
      from_end_q  <= 1'b0;
      status_q    <= 1'b0;
      ord_q       <= 1'b1;
      sort_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIT_POLICY:  pol_q <= cfg_data_i[1:0];
          REG_INITIAL_END: end_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a policy write leaves the list in an unknown order
      if (cfg_we_i && cfg_idx_i == REG_FIT_POLICY) ord_q <= 1'b0;
      else if (state_q == S_APP) ord_q <= 1'b1;
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            from_end_q <= 1'b0;
            status_q   <= 1'b0;
            grant_q    <= '0;
            idx_q      <= '0;
            need_q     <= need_c;
            ins_size_q <= in_item_i.free_size;
            ins_off_q  <= in_item_i.free_offset;
            if (in_item_i.mode == MODE_ALLOC) state_q <= S_SCAN;
            else state_q <= S_INS;
          end
        end
        S_SCAN: begin
          if (idx_q == held_q) begin
            grant_q    <= end_q;
            end_q      <= end_q + OFF_W'(need_q);
            from_end_q <= 1'b1;
            state_q    <= S_DONE;
          end else state_q <= S_SCHK;
        end
        S_SCHK: begin
          if (rd_size >= need_q) begin
            grant_q    <= rd_off;
            total_q    <= total_q - TW'(rd_size);
            ins_size_q <= rd_size - need_q;
            ins_off_q  <= rd_off + OFF_W'(need_q);
            state_q    <= S_SHDN;
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_SCAN;
          end
        end
        S_SHDN: begin
          // read entry idx+1 to move it down
          if (idx_p1 >= held_q) begin
            held_q  <= held_q - HW'(1);
            state_q <= S_INS;
          end else state_q <= S_SHDW;
        end
        S_SHDW: begin
          idx_q   <= idx_p1;
          state_q <= S_SHDN;
        end
        S_INS: begin
          if (ins_size_q == '0) state_q <= S_DONE;
          else if (held_q == HW'(HOLE_SLOTS)) begin
            status_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            held_q  <= held_q + HW'(1);
            total_q <= total_q + TW'(ins_size_q);
            idx_q   <= held_q;
            if (sorted && !ord_q) state_q <= S_APP;
            else state_q <= S_IRD;
          end
        end
        S_APP: begin
          // new hole appended; sort the whole list, one key at a time
          sort_q  <= 1'b1;
          k_q     <= HW'(1);
          state_q <= S_SRD;
        end
        S_SRD: begin
          if (k_q >= held_q) begin
            sort_q  <= 1'b0;
            state_q <= S_DONE;
          end else begin
            idx_q   <= k_q;
            state_q <= S_SLD;
          end
        end
        S_SLD: begin
          ins_size_q <= rd_size;
          ins_off_q  <= rd_off;
          state_q    <= S_IRD;
        end
        S_IRD: state_q <= S_ICHK;
        S_ICHK: begin
          // write happened: shifted entry if ranked after, else the key
          if (shift_up) begin
            idx_q   <= idx_m1;
            state_q <= S_IRD;
          end else if (sort_q) begin
            k_q     <= k_q + HW'(1);
            state_q <= S_SRD;
          end else state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.grant_offset <= grant_q;
            out_q.from_end     <= from_end_q;
            out_q.status       <= status_q;
            out_q.hole_count   <= (held_q > HW'(511)) ? CNT_W'(511) : CNT_W'(held_q);
            out_q.hole_space   <= (total_q > TW'(20'hFFFFF)) ? SPACE_W'(20'hFFFFF)
                                                              : SPACE_W'(total_q);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/hla_checker.sv =====
// Port-level checks for the hole list allocator, bound to the top level.
// Depends on hla_pkg.
`timescale 1ns / 1ps
module hla_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hla_pkg::out_item_t out_item_o
);
  import hla_pkg::*;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.from_end && out_item_o.status))
    else $error("from_end and status both set");
  a_nodbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || !$rose(out_valid_o))
    else $error("result with no work");
endmodule

bind hole_list_allocator hla_checker u_hla_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
);

// ===== verif/tb_hole_list_allocator.sv =====
// Self-checking testbench for hole_list_allocator: a directed table, then random
// phases under every fit policy, including a hole-list overflow. Depends on hla_pkg.
`timescale 1ns / 1ps
module tb_hole_list_allocator;
  import hla_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned LIMIT = 3000000;

  typedef struct {
    bit        typed;
    in_item_t  item;
    out_item_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  // allocator state as the block should hold it
  int unsigned hole_sz[SLOTS];
  int unsigned hole_at[SLOTS];
  int unsigned hole_cnt;
  int unsigned end_ptr;
  int unsigned hole_total;
  logic [1:0]  policy;

  out_item_t   pending_results[$];
  bit          quiet;
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned overflows;
  int unsigned stall_left;

  hole_list_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit ranks_ahead(int unsigned sa, int unsigned oa,
                                     int unsigned sb, int unsigned ob);
    if (policy == POL_BEST) begin
      if (sa != sb) return sa < sb;
      return oa < ob;
    end
    if (sa != sb) return sa > sb;
    return oa < ob;
  endfunction

  // returns 1 when the list is full and the hole is dropped
  function automatic bit push_hole(int unsigned sz, int unsigned at);
    int unsigned s, o, j;
    if (sz == 0) return 1'b0;
    if (hole_cnt >= SLOTS) return 1'b1;
    hole_sz[hole_cnt] = sz;
    hole_at[hole_cnt] = at;
    hole_cnt++;
    hole_total += sz;
    if (policy == POL_BEST || policy == POL_WORST) begin
      for (int unsigned i = 1; i < hole_cnt; i++) begin
        s = hole_sz[i];
        o = hole_at[i];
        j = i;
        while (j > 0 && ranks_ahead(s, o, hole_sz[j-1], hole_at[j-1])) begin
          hole_sz[j] = hole_sz[j-1];
          hole_at[j] = hole_at[j-1];
          j--;
        end
        hole_sz[j] = s;
        hole_at[j] = o;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t allocate_or_free(in_item_t it);
    out_item_t   r;
    int unsigned need, pos, hsz;
    bit          hit;
    r = '0;
    hit = 1'b0;
    pos = 0;
    if (it.mode == MODE_ALLOC) begin
      need = it.payload_len + HEADER_BYTES;
      for (int unsigned i = 0; i < hole_cnt && !hit; i++) begin
        if (hole_sz[i] >= need) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (hit) begin
        hsz = hole_sz[pos];
        r.grant_offset = hole_at[pos];
        hole_total -= hsz;
        for (int unsigned i = pos; i + 1 < hole_cnt; i++) begin
          hole_sz[i] = hole_sz[i+1];
          hole_at[i] = hole_at[i+1];
        end
        hole_cnt--;
        void'(push_hole(hsz - need, r.grant_offset + need));
      end else begin
        r.grant_offset = end_ptr;
        r.from_end = 1'b1;
        end_ptr += need;
      end
    end else begin
      r.status = push_hole(it.free_size, it.free_offset);
    end
    r.hole_count = (hole_cnt > 511) ? 9'd511 : hole_cnt[CNT_W-1:0];
    r.hole_space = (hole_total > 32'hFFFFF) ? 20'hFFFFF : hole_total[SPACE_W-1:0];
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode = 1'($urandom_range(0, 1));
    it.payload_len = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 200))
                                                 : 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 19))
      0:       it.free_size = 11'd0;
      1, 2:    it.free_size = 11'd1027;
      default: it.free_size = 11'($urandom_range(1, 1027));
    endcase
    it.free_offset = $urandom;
    return it;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_FIT_POLICY) begin
      policy = val[1:0];
    end else begin
      end_ptr = val;
    end
  endtask

  // hold valid until accepted, then predict; optional typed expectation
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t exp_r;
    int unsigned gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    exp_r = allocate_or_free(it);
    overflows += exp_r.status;
    pending_results.push_back(typed ? want : exp_r);
    items_sent++;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4 * SLOTS + 20) @(posedge clk_i);
  endtask

  task automatic random_run(int unsigned n);
    repeat (n) send_item(random_item(), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", out_item);
      end else begin
        if (out_item !== pending_results[0]) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: grant %h/%h end %b/%b st %b/%b cnt %0d/%0d space %0d/%0d",
                     pending_results[0].grant_offset, out_item.grant_offset,
                     pending_results[0].from_end, out_item.from_end,
                     pending_results[0].status, out_item.status,
                     pending_results[0].hole_count, out_item.hole_count,
                     pending_results[0].hole_space, out_item.hole_space);
        end
        void'(pending_results.pop_front());
      end
    end
    // stall in short bursts, none in the quiet tail
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    dir_row_t rows[];
    in_item_t fill;
    rows = '{
      '{1'b1, '{MODE_ALLOC, 10'd0, 11'd0, 32'd0},          '{32'd0, 1'b1, 1'b0, 9'd0, 20'd0}},
      '{1'b1, '{MODE_ALLOC, 10'd1023, 11'd0, 32'd0},       '{32'd4, 1'b1, 1'b0, 9'd0, 20'd0}},
      '{1'b1, '{MODE_FREE, 10'd0, 11'd0, 32'd123},         '{32'd0, 1'b0, 1'b0, 9'd0, 20'd0}},
      '{1'b1, '{MODE_FREE, 10'h3FF, 11'd1027, 32'hFFFFFFFF},
                                                   '{32'd0, 1'b0, 1'b0, 9'd1, 20'd1027}},
      '{1'b1, '{MODE_FREE, 10'd0, 11'd100, 32'd5000},      '{32'd0, 1'b0, 1'b0, 9'd2, 20'd1127}},
      '{1'b1, '{MODE_ALLOC, 10'd96, 11'h7FF, 32'd0},
                                            '{32'hFFFFFFFF, 1'b0, 1'b0, 9'd2, 20'd1027}},
      '{1'b1, '{MODE_ALLOC, 10'd96, 11'd0, 32'd0},         '{32'd5000, 1'b0, 1'b0, 9'd1, 20'd927}},
      '{1'b1, '{MODE_ALLOC, 10'd1023, 11'd0, 32'd0},       '{32'd1031, 1'b1, 1'b0, 9'd1, 20'd927}},
      '{1'b1, '{MODE_FREE, 10'd0, 11'd1, 32'd0},           '{32'd0, 1'b0, 1'b0, 9'd2, 20'd928}},
      '{1'b1, '{MODE_ALLOC, 10'd0, 11'd0, 32'd0},          '{32'd99, 1'b0, 1'b0, 9'd2, 20'd924}},
      '{1'b0, '{MODE_FREE, 10'd0, 11'd4, 32'hAAAAAAAA},    '0},
      '{1'b0, '{MODE_FREE, 10'd0, 11'd500, 32'h55555555},  '0},
      '{1'b0, '{MODE_FREE, 10'd0, 11'h400, 32'h00000010},  '0},
      '{1'b0, '{MODE_ALLOC, 10'd496, 11'd0, 32'd0},        '0},
      '{1'b0, '{MODE_ALLOC, 10'd0, 11'd0, 32'd0},          '0},
      '{1'b0, '{MODE_ALLOC, 10'h155, 11'h2AA, 32'd0},      '0},
      '{1'b0, '{MODE_ALLOC, 10'h2AA, 11'h555, 32'd0},      '0},
      '{1'b0, '{MODE_ALLOC, 10'd1023, 11'd0, 32'd0},       '0}
    };
    hole_cnt = 0;
    hole_total = 0;
    end_ptr = 0;
    policy = POL_FIRST;
    quiet = 1'b0;
    cycles = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    overflows = 0;
    stall_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // best fit, end pointer near the top so appends wrap
    write_reg(REG_FIT_POLICY, CFG_W'(POL_BEST));
    write_reg(REG_INITIAL_END, 32'hFFFFFF00);
    random_run(100);
    drain();

    write_reg(REG_FIT_POLICY, CFG_W'(POL_WORST));
    write_reg(REG_INITIAL_END, 32'hFFFFFFFF);
    random_run(100);
    drain();

    // unused policy code; fill the list past its capacity
    write_reg(REG_FIT_POLICY, CFG_W'(POL_UNUSED));
    for (int i = 0; i < SLOTS + 3; i++) begin
      fill = random_item();
      fill.mode = MODE_FREE;
      fill.free_size = 11'($urandom_range(1, 1027));
      send_item(fill, 1'b0, '0);
    end
    random_run(60);
    drain();

    write_reg(REG_FIT_POLICY, CFG_W'(POL_WORST));
    random_run(40);
    drain();

    write_reg(REG_FIT_POLICY, CFG_W'(POL_FIRST));
    write_reg(REG_INITIAL_END, 32'd0);
    random_run(60);
    quiet = 1'b1;
    random_run(80);
    drain();

    $display("Sent %0d items under all four policy codes, %0d results checked,", items_sent,
             results_seen);
    $display("%0d frees dropped on a full list, %0d mismatches", overflows, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
